// ===== rtl/ldf_pkg.sv =====
// ============================================================================
// ldf_pkg: types, tables and helpers for the luma deblocking edge filter
// Payload structs, register indexes, beta/tC tables, the per-lane control type.
// ============================================================================
package ldf_pkg;

    typedef struct packed {
        logic       keep_q;
        logic       keep_p;
        logic [5:0] qp_q_side;
        logic [5:0] qp_p_side;
        logic [1:0] strength;
        logic [63:0] line_3;
        logic [63:0] line_2;
        logic [63:0] line_1;
        logic [63:0] line_0;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  decision;
        logic [63:0] out_line_3;
        logic [63:0] out_line_2;
        logic [63:0] out_line_1;
        logic [63:0] out_line_0;
    } t_out_item;

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_NORMAL = 2'd1,
        DEC_STRONG = 2'd2
    } t_decision;

    localparam logic REG_BETA_OFS = 1'b0;
    localparam logic REG_TC_OFS   = 1'b1;

    localparam int NUM_LINES = 4;

    // shared control from the decision stage to each line lane
    typedef struct packed {
        logic       filt_en;
        logic       use_strong;
        logic       dep;
        logic       deq;
        logic       byp;
        logic       byq;
        logic [4:0] tc;
    } t_lane_ctrl;

    function automatic logic [6:0] beta_lut(input logic [5:0] idx);
        logic [6:0] r;
        begin
            if (idx < 6'd16)      r = 7'd0;
            else if (idx < 6'd29) r = 7'(idx - 6'd10);
            else if (idx < 6'd52) r = 7'({1'b0, idx} * 7'd2 - 7'd38);
            else                  r = 7'd64;
            return r;
        end
    endfunction

    function automatic logic [4:0] tc_lut(input logic [5:0] idx);
        logic [4:0] r;
        begin
            case (idx)
                6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
                6'd26: r = 5'd1;
                6'd27, 6'd28, 6'd29, 6'd30: r = 5'd2;
                6'd31, 6'd32, 6'd33, 6'd34: r = 5'd3;
                6'd35, 6'd36, 6'd37: r = 5'd4;
                6'd38, 6'd39: r = 5'd5;
                6'd40, 6'd41: r = 5'd6;
                6'd42: r = 5'd7;
                6'd43: r = 5'd8;
                6'd44: r = 5'd9;
                6'd45: r = 5'd10;
                6'd46: r = 5'd11;
                6'd47: r = 5'd13;
                6'd48: r = 5'd14;
                6'd49: r = 5'd16;
                6'd50: r = 5'd18;
                6'd51: r = 5'd20;
                6'd52: r = 5'd22;
                6'd53: r = 5'd24;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] clip_pix(input logic signed [11:0] v);
        logic [7:0] r;
        begin
            if (v < 0)            r = 8'd0;
            else if (v > 12'sd255) r = 8'd255;
            else                  r = v[7:0];
            return r;
        end
    endfunction

    // |p - 2q + r| on 8-bit samples
    function automatic logic [8:0] sec_diff(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
        logic signed [10:0] v;
        begin
            v = $signed({3'b0, a}) - $signed({2'b0, b, 1'b0}) + $signed({3'b0, c});
            return (v < 0) ? 9'(-v) : v[8:0];
        end
    endfunction

    function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? 8'(a - b) : 8'(b - a);
    endfunction

endpackage

// ===== rtl/ldf_decide.sv =====
// ============================================================================
// ldf_decide: edge decision
// Derives beta and tC, evaluates d, dSam and dEp/dEq on lines 0 and 3.
// ============================================================================
module ldf_decide
    import ldf_pkg::*;
(
    input  t_in_item        i_item,
    input  logic signed [3:0] i_beta_ofs,
    input  logic signed [3:0] i_tc_ofs,
    output t_lane_ctrl      o_ctrl,
    output t_decision       o_decision
);
    logic [1:0] bs;
    logic [5:0] qpl;
    logic signed [8:0] bidx, tidx;
    logic [5:0] bidx_c, tidx_c;
    logic [6:0] beta;
    logic [4:0] tc;
    logic [8:0] dp0, dp3, dq0, dq3;
    logic [10:0] d;
    logic [9:0] dpq0, dpq3, dps, dqs;
    logic [6:0] side;
    logic [6:0] tc_lim;
    logic sam0, sam3, filt;
    logic [7:0] s0 [8];
    logic [7:0] s3 [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            s0[k] = i_item.line_0[8*k +: 8];
            s3[k] = i_item.line_3[8*k +: 8];
        end
        bs   = (i_item.strength == 2'd3) ? 2'd2 : i_item.strength;
        qpl  = 6'(({1'b0, i_item.qp_p_side} + {1'b0, i_item.qp_q_side} + 7'd1) >> 1);
        bidx = $signed({3'b0, qpl}) + 9'(i_beta_ofs * 2);
        tidx = $signed({3'b0, qpl}) + 9'(i_tc_ofs * 2) + ((bs == 2'd2) ? 9'sd2 : 9'sd0);
        bidx_c = (bidx < 0) ? 6'd0 : ((bidx > 9'sd51) ? 6'd51 : bidx[5:0]);
        tidx_c = (tidx < 0) ? 6'd0 : ((tidx > 9'sd53) ? 6'd53 : tidx[5:0]);
        beta = beta_lut(bidx_c);
        tc   = tc_lut(tidx_c);
        dp0 = sec_diff(s0[1], s0[2], s0[3]);
        dp3 = sec_diff(s3[1], s3[2], s3[3]);
        dq0 = sec_diff(s0[6], s0[5], s0[4]);
        dq3 = sec_diff(s3[6], s3[5], s3[4]);
        dpq0 = {1'b0, dp0} + {1'b0, dq0};
        dpq3 = {1'b0, dp3} + {1'b0, dq3};
        dps  = {1'b0, dp0} + {1'b0, dp3};
        dqs  = {1'b0, dq0} + {1'b0, dq3};
        d    = {1'b0, dpq0} + {1'b0, dpq3};
        side = 7'(({1'b0, beta} + {2'b0, beta[6:1]}) >> 3);
        tc_lim = 7'(({2'b0, tc} * 7'd5 + 7'd1) >> 1);
        sam0 = ({dpq0, 1'b0} < {6'b0, beta[6:2]})
            && ({1'b0, abs_diff(s0[0], s0[3])} + {1'b0, abs_diff(s0[4], s0[7])}
                < {5'b0, beta[6:3]})
            && ({1'b0, abs_diff(s0[3], s0[4])} < {2'b0, tc_lim});
        sam3 = ({dpq3, 1'b0} < {6'b0, beta[6:2]})
            && ({1'b0, abs_diff(s3[0], s3[3])} + {1'b0, abs_diff(s3[4], s3[7])}
                < {5'b0, beta[6:3]})
            && ({1'b0, abs_diff(s3[3], s3[4])} < {2'b0, tc_lim});
        filt = (bs != 2'd0) && (d < {4'b0, beta});
        o_ctrl.filt_en    = filt;
        o_ctrl.use_strong = sam0 && sam3;
        o_ctrl.dep        = dps < {3'b0, side};
        o_ctrl.deq        = dqs < {3'b0, side};
        o_ctrl.byp        = i_item.keep_p;
        o_ctrl.byq        = i_item.keep_q;
        o_ctrl.tc         = tc;
        if (!filt)             o_decision = DEC_NONE;
        else if (sam0 && sam3) o_decision = DEC_STRONG;
        else                   o_decision = DEC_NORMAL;
    end
endmodule

// ===== rtl/ldf_lane.sv =====
// ============================================================================
// ldf_lane: one-line filter
// Applies strong or normal filtering to one line of eight samples.
// ============================================================================
module ldf_lane
    import ldf_pkg::*;
(
    input  logic [63:0] i_line,
    input  t_lane_ctrl  i_ctrl,
    output logic [63:0] o_line
);
    logic signed [11:0] p3, p2, p1, p0, q0, q1, q2, q3;
    logic signed [11:0] t2, tcs, th, dl, dlc, dpv, dqv, ad;
    logic signed [13:0] dl_raw;
    logic signed [11:0] sp0, sp1, sp2, sq0, sq1, sq2;
    logic [7:0] o [8];

    function automatic logic signed [11:0] clip3(input logic signed [11:0] lo,
                                                 input logic signed [11:0] hi,
                                                 input logic signed [11:0] v);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    always_comb begin
        for (int k = 0; k < 8; k++) o[k] = i_line[8*k +: 8];
        p3 = $signed({4'b0, i_line[7:0]});
        p2 = $signed({4'b0, i_line[15:8]});
        p1 = $signed({4'b0, i_line[23:16]});
        p0 = $signed({4'b0, i_line[31:24]});
        q0 = $signed({4'b0, i_line[39:32]});
        q1 = $signed({4'b0, i_line[47:40]});
        q2 = $signed({4'b0, i_line[55:48]});
        q3 = $signed({4'b0, i_line[63:56]});
        tcs = $signed({7'b0, i_ctrl.tc});
        t2  = tcs <<< 1;
        th  = tcs >>> 1;
        sp0 = clip3(p0 - t2, p0 + t2,
                    (p2 + 12'sd2*p1 + 12'sd2*p0 + 12'sd2*q0 + q1 + 12'sd4) >>> 3);
        sp1 = clip3(p1 - t2, p1 + t2, (p2 + p1 + p0 + q0 + 12'sd2) >>> 2);
        sp2 = clip3(p2 - t2, p2 + t2,
                    (12'sd2*p3 + 12'sd3*p2 + p1 + p0 + q0 + 12'sd4) >>> 3);
        sq0 = clip3(q0 - t2, q0 + t2,
                    (p1 + 12'sd2*p0 + 12'sd2*q0 + 12'sd2*q1 + q2 + 12'sd4) >>> 3);
        sq1 = clip3(q1 - t2, q1 + t2, (p0 + q0 + q1 + q2 + 12'sd2) >>> 2);
        sq2 = clip3(q2 - t2, q2 + t2,
                    (p0 + q0 + q1 + 12'sd3*q2 + 12'sd2*q3 + 12'sd4) >>> 3);
        // raw delta spans about +-3070 before the shift
        dl_raw = 14'sd9 * 14'(q0 - p0) - 14'sd3 * 14'(q1 - p1) + 14'sd8;
        dl  = 12'(dl_raw >>> 4);
        ad  = (dl < 0) ? -dl : dl;
        dlc = clip3(-tcs, tcs, dl);
        dpv = clip3(-th, th, ((((p2 + p0 + 12'sd1) >>> 1) - p1 + dlc) >>> 1));
        dqv = clip3(-th, th, ((((q2 + q0 + 12'sd1) >>> 1) - q1 - dlc) >>> 1));
        if (i_ctrl.filt_en) begin
            if (i_ctrl.use_strong) begin
                if (!i_ctrl.byp) begin
                    o[3] = sp0[7:0];
                    o[2] = sp1[7:0];
                    o[1] = sp2[7:0];
                end
                if (!i_ctrl.byq) begin
                    o[4] = sq0[7:0];
                    o[5] = sq1[7:0];
                    o[6] = sq2[7:0];
                end
            end else if (ad < tcs * 12'sd10) begin
                if (!i_ctrl.byp) o[3] = clip_pix(p0 + dlc);
                if (!i_ctrl.byq) o[4] = clip_pix(q0 - dlc);
                if (i_ctrl.dep && !i_ctrl.byp) o[2] = clip_pix(p1 + dpv);
                if (i_ctrl.deq && !i_ctrl.byq) o[5] = clip_pix(q1 + dqv);
            end
        end
        for (int k = 0; k < 8; k++) o_line[8*k +: 8] = o[k];
    end
endmodule

// ===== rtl/luma_deblock_edge_filter.sv =====
// ============================================================================
// luma_deblock_edge_filter: HEVC 8-bit luma deblocking of a 4-line edge
// Decision stage feeds four line lanes; lanes merge into one output beat.
// ============================================================================
// channel | signals                 | direction
// input   | i_valid/o_ready, i_item | in
// output  | o_valid/i_ready, o_item | out
// config  | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// One beat per cycle unless the output stalls; input register, then output register.
// Decision and line lanes form one stage; the skid-free output register sets
// the rate: input is taken when the input register is empty or the output
// register is empty or drained. Reset clears valids and both offset registers.
module luma_deblock_edge_filter
    import ldf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    logic signed [3:0] r_beta_ofs, r_tc_ofs;
    logic r_s1_valid, r_valid;
    t_in_item r_s1_item;
    t_out_item r_out;
    logic s1_ready;
    t_lane_ctrl ctrl;
    t_decision  dec;
    logic [63:0] lane_in  [NUM_LINES];
    logic [63:0] lane_out [NUM_LINES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beta_ofs <= '0;
            r_tc_ofs   <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_BETA_OFS) r_beta_ofs <= i_cfg_data;
            if (i_cfg_index == REG_TC_OFS)   r_tc_ofs   <= i_cfg_data;
        end
    end

    assign s1_ready = !r_valid || i_ready;
    assign o_ready  = !r_s1_valid || s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (o_ready)  r_s1_valid <= i_valid;
            if (s1_ready) r_valid    <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_s1_item <= i_item;
        if (s1_ready && r_s1_valid) begin
            r_out.out_line_0 <= lane_out[0];
            r_out.out_line_1 <= lane_out[1];
            r_out.out_line_2 <= lane_out[2];
            r_out.out_line_3 <= lane_out[3];
            r_out.decision   <= dec;
        end
    end

    ldf_decide u_decide (
        .i_item     (r_s1_item),
        .i_beta_ofs (r_beta_ofs),
        .i_tc_ofs   (r_tc_ofs),
        .o_ctrl     (ctrl),
        .o_decision (dec)
    );

    assign lane_in[0] = r_s1_item.line_0;
    assign lane_in[1] = r_s1_item.line_1;
    assign lane_in[2] = r_s1_item.line_2;
    assign lane_in[3] = r_s1_item.line_3;

    for (genvar g = 0; g < NUM_LINES; g++) begin : g_lane
        ldf_lane u_lane (
            .i_line (lane_in[g]),
            .i_ctrl (ctrl),
            .o_line (lane_out[g])
        );
    end

    assign o_valid = r_valid;
    assign o_item  = r_out;
endmodule

// ===== rtl/ldf_checker.sv =====
// ============================================================================
// ldf_checker: port-level checks
// Handshake and result sanity on the top-level ports.
// ============================================================================
module ldf_checker
    import ldf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_item
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output beat dropped or changed while stalled");

    a_dec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.decision <= DEC_STRONG)
        else $error("illegal decision code");

    a_ready_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid, 2) || $past(i_valid, 3) || $past(o_valid, 2)
            || !$past(i_rst_n, 2) || $past(o_ready, 1) == 1'b0 || $past(i_valid, 1))
        else $error("result without an input beat");
endmodule

bind luma_deblock_edge_filter ldf_checker u_ldf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);
